[rtl/i2cm_pkg.sv]
// Shared types and constants for the I2C master byte engine.
// Used by the channel interfaces and every RTL module; depends on nothing.
`default_nettype none

package i2cm_pkg;

  localparam int unsigned KIND_W     = 2;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned BITCNT_W   = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned STEP_W     = 23;

  localparam logic [TICK_W-1:0]   HALF_PERIOD_RST = 16'd72;
  localparam logic [TICK_W-1:0]   ACK_TIMEOUT_RST = 16'd250;
  localparam logic [BITCNT_W-1:0] BITS_PER_BYTE   = 4'd8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT = 2'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_START = 2'd0,
    KIND_STOP  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_READ  = 2'd3
  } kind_e;

  // Bus sequencer steps, one-hot.
  typedef enum logic [STEP_W-1:0] {
    ST_IDLE  = 23'h000001,
    ST_S_A   = 23'h000002,
    ST_S_B   = 23'h000004,
    ST_S_C   = 23'h000008,
    ST_P_A   = 23'h000010,
    ST_P_B   = 23'h000020,
    ST_P_C   = 23'h000040,
    ST_W_BIT = 23'h000080,
    ST_W_HI  = 23'h000100,
    ST_W_LO  = 23'h000200,
    ST_A_REL = 23'h000400,
    ST_A_HI  = 23'h000800,
    ST_A_LO  = 23'h001000,
    ST_N_LO  = 23'h002000,
    ST_N_SDA = 23'h004000,
    ST_N_HI  = 23'h008000,
    ST_N_REL = 23'h010000,
    ST_R_HI  = 23'h020000,
    ST_R_LO  = 23'h040000,
    ST_K_SDA = 23'h080000,
    ST_K_HI  = 23'h100000,
    ST_K_LO  = 23'h200000,
    ST_K_REL = 23'h400000
  } step_e;

  typedef struct packed {
    logic              cmd_valid;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] wr_data;
    logic              send_ack;
    logic              sda_in;
  } cmd_t;

  typedef struct packed {
    logic              scl_out;
    logic              sda_out;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rd_data;
    logic              nack;
  } res_t;

  typedef struct packed {
    logic [TICK_W-1:0] half_period;
    logic [TICK_W-1:0] ack_timeout;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/i2cm_if.sv]
// Channel interfaces of the I2C master byte engine: tick input, result and
// configuration write. Depends on i2cm_pkg for field widths.
`default_nettype none

interface i2cm_in_if;
  logic                          valid;
  logic                          ready;
  logic                          cmd_valid;
  logic [i2cm_pkg::KIND_W-1:0]   kind;
  logic [i2cm_pkg::BYTE_W-1:0]   wr_data;
  logic                          send_ack;
  logic                          sda_in;

  modport source (output valid, cmd_valid, kind, wr_data, send_ack, sda_in, input ready);
  modport sink   (input valid, cmd_valid, kind, wr_data, send_ack, sda_in, output ready);
endinterface

interface i2cm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          scl_out;
  logic                          sda_out;
  logic                          busy_res;
  logic                          done_res;
  logic [i2cm_pkg::BYTE_W-1:0]   rd_data;
  logic                          nack;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rd_data, nack,
                  input ready);
  modport sink   (input valid, scl_out, sda_out, busy_res, done_res, rd_data, nack,
                  output ready);
endinterface

interface i2cm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [i2cm_pkg::CFG_IDX_W-1:0]    index;
  logic [i2cm_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[rtl/i2cm_cfg.sv]
// Configuration registers: half-period tick count and acknowledge timeout.
// Depends on i2cm_pkg and the i2cm_cfg_if interface.
`default_nettype none

module i2cm_cfg (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  i2cm_cfg_if.sink        cfg_i,
  output i2cm_pkg::cfg_t  cfg_o
);

  i2cm_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      if (cfg_i.index == i2cm_pkg::CFG_HALF_PERIOD) begin
        cfg_d.half_period = cfg_i.data;
      end else if (cfg_i.index == i2cm_pkg::CFG_ACK_TIMEOUT) begin
        cfg_d.ack_timeout = cfg_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period <= i2cm_pkg::HALF_PERIOD_RST;
      cfg_q.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/i2cm_seq.sv]
// Bus sequencer: pin levels, bit shifting, wait and acknowledge counters.
// Advances one tick per enable. Depends on i2cm_pkg.
`default_nettype none

module i2cm_seq (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       tick_i,
  input  i2cm_pkg::cmd_t  cmd_i,
  input  i2cm_pkg::cfg_t  cfg_i,
  output i2cm_pkg::res_t  res_o
);

  i2cm_pkg::step_e                   step_q, step_d, enter_st;
  logic                              enter_en;
  logic                              done;
  logic [i2cm_pkg::BITCNT_W-1:0]     bit_q, bit_d;
  logic [i2cm_pkg::BYTE_W-1:0]       shift_q, shift_d;
  logic [i2cm_pkg::TICK_W-1:0]       delay_q, delay_d;
  logic [i2cm_pkg::TICK_W-1:0]       wait_q, wait_d;
  logic                              ack_choice_q, ack_choice_d;
  logic                              scl_q, scl_d;
  logic                              sda_q, sda_d;
  logic                              nack_q, nack_d;
  logic [i2cm_pkg::BYTE_W-1:0]       rd_q, rd_d;

  always_comb begin
    step_d       = step_q;
    bit_d        = bit_q;
    shift_d      = shift_q;
    delay_d      = delay_q;
    wait_d       = wait_q;
    ack_choice_d = ack_choice_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    nack_d       = nack_q;
    rd_d         = rd_q;
    done         = 1'b0;
    enter_en     = 1'b0;
    enter_st     = i2cm_pkg::ST_IDLE;

    if (tick_i) begin
      if (step_q == i2cm_pkg::ST_IDLE) begin
        if (cmd_i.cmd_valid) begin
          enter_en = 1'b1;
          unique case (i2cm_pkg::kind_e'(cmd_i.kind))
            i2cm_pkg::KIND_START: enter_st = i2cm_pkg::ST_S_A;
            i2cm_pkg::KIND_STOP:  enter_st = i2cm_pkg::ST_P_A;
            i2cm_pkg::KIND_WRITE: begin
              shift_d  = cmd_i.wr_data;
              bit_d    = '0;
              nack_d   = 1'b0;
              wait_d   = '0;
              enter_st = i2cm_pkg::ST_W_BIT;
            end
            i2cm_pkg::KIND_READ: begin
              shift_d      = '0;
              bit_d        = '0;
              ack_choice_d = cmd_i.send_ack;
              enter_st     = i2cm_pkg::ST_R_HI;
            end
            default: enter_en = 1'b0;
          endcase
        end
      end else if (delay_q != '0) begin
        delay_d = delay_q - 1'b1;
      end else begin
        enter_en = 1'b1;
        unique case (step_q)
          i2cm_pkg::ST_S_A:   enter_st = i2cm_pkg::ST_S_B;
          i2cm_pkg::ST_S_B:   enter_st = i2cm_pkg::ST_S_C;
          i2cm_pkg::ST_P_A:   enter_st = i2cm_pkg::ST_P_B;
          i2cm_pkg::ST_P_B:   enter_st = i2cm_pkg::ST_P_C;
          i2cm_pkg::ST_W_BIT: enter_st = i2cm_pkg::ST_W_HI;
          i2cm_pkg::ST_W_HI:  enter_st = i2cm_pkg::ST_W_LO;
          i2cm_pkg::ST_W_LO: begin
            enter_st = (bit_q >= i2cm_pkg::BITS_PER_BYTE) ? i2cm_pkg::ST_A_REL
                                                          : i2cm_pkg::ST_W_BIT;
          end
          i2cm_pkg::ST_A_REL: enter_st = i2cm_pkg::ST_A_HI;
          i2cm_pkg::ST_A_HI: begin
            // Poll SDA with SCL high; a missing acknowledge ends in a stop.
            if (!cmd_i.sda_in) begin
              enter_st = i2cm_pkg::ST_A_LO;
            end else if (wait_q >= cfg_i.ack_timeout) begin
              nack_d   = 1'b1;
              enter_st = i2cm_pkg::ST_N_LO;
            end else begin
              enter_en = 1'b0;
              wait_d   = wait_q + 1'b1;
            end
          end
          i2cm_pkg::ST_N_LO:  enter_st = i2cm_pkg::ST_N_SDA;
          i2cm_pkg::ST_N_SDA: enter_st = i2cm_pkg::ST_N_HI;
          i2cm_pkg::ST_N_HI:  enter_st = i2cm_pkg::ST_N_REL;
          i2cm_pkg::ST_R_HI: begin
            shift_d  = {shift_q[i2cm_pkg::BYTE_W-2:0], cmd_i.sda_in};
            bit_d    = bit_q + 1'b1;
            enter_st = i2cm_pkg::ST_R_LO;
          end
          i2cm_pkg::ST_R_LO: begin
            if (bit_q >= i2cm_pkg::BITS_PER_BYTE) begin
              rd_d     = shift_q;
              enter_st = i2cm_pkg::ST_K_SDA;
            end else begin
              enter_st = i2cm_pkg::ST_R_HI;
            end
          end
          i2cm_pkg::ST_K_SDA: enter_st = i2cm_pkg::ST_K_HI;
          i2cm_pkg::ST_K_HI:  enter_st = i2cm_pkg::ST_K_LO;
          i2cm_pkg::ST_K_LO: begin
            if (ack_choice_q) begin
              enter_st = i2cm_pkg::ST_K_REL;
            end else begin
              enter_en = 1'b0;
              step_d   = i2cm_pkg::ST_IDLE;
              done     = 1'b1;
            end
          end
          i2cm_pkg::ST_S_C, i2cm_pkg::ST_P_C, i2cm_pkg::ST_A_LO,
          i2cm_pkg::ST_N_REL, i2cm_pkg::ST_K_REL: begin
            enter_en = 1'b0;
            step_d   = i2cm_pkg::ST_IDLE;
            done     = 1'b1;
          end
          default: begin
            enter_en = 1'b0;
            step_d   = i2cm_pkg::ST_IDLE;
          end
        endcase
      end
    end

    // Entering a step performs its pin action and reloads the wait.
    if (enter_en) begin
      step_d  = enter_st;
      delay_d = (cfg_i.half_period == '0) ? '0 : cfg_i.half_period - 1'b1;
      unique case (enter_st)
        i2cm_pkg::ST_S_A: begin
          sda_d = 1'b1;
          scl_d = 1'b1;
        end
        i2cm_pkg::ST_S_B:   sda_d = 1'b0;
        i2cm_pkg::ST_S_C:   scl_d = 1'b0;
        i2cm_pkg::ST_P_A:   sda_d = 1'b0;
        i2cm_pkg::ST_P_B:   scl_d = 1'b1;
        i2cm_pkg::ST_P_C:   sda_d = 1'b1;
        i2cm_pkg::ST_W_BIT: sda_d = shift_d[i2cm_pkg::BYTE_W-1];
        i2cm_pkg::ST_W_HI:  scl_d = 1'b1;
        i2cm_pkg::ST_W_LO: begin
          scl_d   = 1'b0;
          shift_d = {shift_d[i2cm_pkg::BYTE_W-2:0], 1'b0};
          bit_d   = bit_d + 1'b1;
        end
        i2cm_pkg::ST_A_REL: sda_d = 1'b1;
        i2cm_pkg::ST_A_HI: begin
          scl_d  = 1'b1;
          wait_d = '0;
        end
        i2cm_pkg::ST_A_LO:  scl_d = 1'b0;
        i2cm_pkg::ST_N_LO:  scl_d = 1'b0;
        i2cm_pkg::ST_N_SDA: sda_d = 1'b0;
        i2cm_pkg::ST_N_HI:  scl_d = 1'b1;
        i2cm_pkg::ST_N_REL: sda_d = 1'b1;
        i2cm_pkg::ST_R_HI: begin
          sda_d = 1'b1;
          scl_d = 1'b1;
        end
        i2cm_pkg::ST_R_LO:  scl_d = 1'b0;
        i2cm_pkg::ST_K_SDA: sda_d = ~ack_choice_d;
        i2cm_pkg::ST_K_HI:  scl_d = 1'b1;
        i2cm_pkg::ST_K_LO:  scl_d = 1'b0;
        i2cm_pkg::ST_K_REL: sda_d = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= i2cm_pkg::ST_IDLE;
      bit_q        <= '0;
      shift_q      <= '0;
      delay_q      <= '0;
      wait_q       <= '0;
      ack_choice_q <= 1'b0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      nack_q       <= 1'b0;
      rd_q         <= '0;
    end else begin
      step_q       <= step_d;
      bit_q        <= bit_d;
      shift_q      <= shift_d;
      delay_q      <= delay_d;
      wait_q       <= wait_d;
      ack_choice_q <= ack_choice_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      nack_q       <= nack_d;
      rd_q         <= rd_d;
    end
  end

  // The result reports the state after this tick's update.
  always_comb begin
    res_o.scl_out  = scl_d;
    res_o.sda_out  = sda_d;
    res_o.busy_res = (step_d != i2cm_pkg::ST_IDLE);
    res_o.done_res = done;
    res_o.rd_data  = rd_d;
    res_o.nack     = nack_d;
  end

endmodule

`default_nettype wire

[rtl/i2c_master_byte_engine.sv]
// I2C master byte engine: one tick beat in, one result beat out.
// A tick beat is registered at the input, then its result in the result register.
// Throughput: one tick per clock cycle while the result receiver keeps ready high.
// Reset: asynchronous and active low; bus released, sequencer idle, half period 72,
// acknowledge timeout 250. Depends on i2cm_pkg, the interfaces, i2cm_cfg and i2cm_seq.
`default_nettype none

module i2c_master_byte_engine (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  i2cm_in_if.sink     in_i,
  i2cm_out_if.source  res_o,
  i2cm_cfg_if.sink    cfg_i
);

  logic            in_valid_q;
  i2cm_pkg::cmd_t  in_pl_q;
  logic            out_valid_q;
  i2cm_pkg::res_t  out_pl_q;
  i2cm_pkg::cfg_t  cfg;
  i2cm_pkg::res_t  seq_res;
  logic            advance;
  logic            tick;

  assign advance    = !out_valid_q || res_o.ready;
  assign tick       = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  i2cm_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  i2cm_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick),
    .cmd_i  (in_pl_q),
    .cfg_i  (cfg),
    .res_o  (seq_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_pl_q.cmd_valid <= in_i.cmd_valid;
      in_pl_q.kind      <= in_i.kind;
      in_pl_q.wr_data   <= in_i.wr_data;
      in_pl_q.send_ack  <= in_i.send_ack;
      in_pl_q.sda_in    <= in_i.sda_in;
    end
    if (tick) begin
      out_pl_q <= seq_res;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.scl_out  = out_pl_q.scl_out;
  assign res_o.sda_out  = out_pl_q.sda_out;
  assign res_o.busy_res = out_pl_q.busy_res;
  assign res_o.done_res = out_pl_q.done_res;
  assign res_o.rd_data  = out_pl_q.rd_data;
  assign res_o.nack     = out_pl_q.nack;

`ifndef ASSERT_OFF
  // A finishing command leaves the sequencer idle in the same beat.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.done_res) |-> !res_o.busy_res)
    else $error("done pulse while still busy");

  // Every processed tick produces a result beat in the next cycle.
  a_tick_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick |=> out_valid_q)
    else $error("processed tick lost its result");

  // With the result register empty the input side is never stalled.
  a_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");
`endif

endmodule

`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for the I2C master byte engine: drives tick beats with random
// gaps, predicts every pin/status result and checks each result beat in order.
// Depends on i2cm_pkg, the channel interfaces and the i2c_master_byte_engine RTL.

class bus_pin_scoreboard;
  // Sequencer copy kept in step with every accepted tick beat.
  i2cm_pkg::step_e                 step;
  logic [i2cm_pkg::BITCNT_W-1:0]   bit_cnt;
  logic [i2cm_pkg::BYTE_W-1:0]     shreg;
  logic [i2cm_pkg::TICK_W-1:0]     delay;
  logic [i2cm_pkg::TICK_W-1:0]     ack_wait;
  logic                            ack_sel;
  logic                            scl;
  logic                            sda;
  logic                            nack_f;
  logic [i2cm_pkg::BYTE_W-1:0]     rdbyte;
  logic [i2cm_pkg::TICK_W-1:0]     half_period;
  logic [i2cm_pkg::TICK_W-1:0]     ack_timeout;

  i2cm_pkg::res_t pins_due[$];
  int             errors;
  int             ticks_seen;

  function new();
    step        = i2cm_pkg::ST_IDLE;
    bit_cnt     = '0;
    shreg       = '0;
    delay       = '0;
    ack_wait    = '0;
    ack_sel     = 1'b0;
    scl         = 1'b1;
    sda         = 1'b1;
    nack_f      = 1'b0;
    rdbyte      = '0;
    half_period = i2cm_pkg::HALF_PERIOD_RST;
    ack_timeout = i2cm_pkg::ACK_TIMEOUT_RST;
    errors      = 0;
    ticks_seen  = 0;
  endfunction

  function void write_reg(logic [i2cm_pkg::CFG_IDX_W-1:0] idx,
                          logic [i2cm_pkg::CFG_DATA_W-1:0] val);
    if (idx == i2cm_pkg::CFG_HALF_PERIOD) begin
      half_period = val;
    end else if (idx == i2cm_pkg::CFG_ACK_TIMEOUT) begin
      ack_timeout = val;
    end
  endfunction

  function bit seq_busy();
    return step != i2cm_pkg::ST_IDLE;
  endfunction

  function int pending();
    return pins_due.size();
  endfunction

  // Each step does its pin action on entry and then waits out one half period.
  function void enter_step(i2cm_pkg::step_e s);
    step = s;
    case (s)
      i2cm_pkg::ST_S_A:   begin sda = 1'b1; scl = 1'b1; end
      i2cm_pkg::ST_S_B:   sda = 1'b0;
      i2cm_pkg::ST_S_C:   scl = 1'b0;
      i2cm_pkg::ST_P_A:   sda = 1'b0;
      i2cm_pkg::ST_P_B:   scl = 1'b1;
      i2cm_pkg::ST_P_C:   sda = 1'b1;
      i2cm_pkg::ST_W_BIT: sda = shreg[i2cm_pkg::BYTE_W-1];
      i2cm_pkg::ST_W_HI:  scl = 1'b1;
      i2cm_pkg::ST_W_LO:  begin
        scl     = 1'b0;
        shreg   = {shreg[i2cm_pkg::BYTE_W-2:0], 1'b0};
        bit_cnt = bit_cnt + 1'b1;
      end
      i2cm_pkg::ST_A_REL: sda = 1'b1;
      i2cm_pkg::ST_A_HI:  begin scl = 1'b1; ack_wait = '0; end
      i2cm_pkg::ST_A_LO:  scl = 1'b0;
      i2cm_pkg::ST_N_LO:  scl = 1'b0;
      i2cm_pkg::ST_N_SDA: sda = 1'b0;
      i2cm_pkg::ST_N_HI:  scl = 1'b1;
      i2cm_pkg::ST_N_REL: sda = 1'b1;
      i2cm_pkg::ST_R_HI:  begin sda = 1'b1; scl = 1'b1; end
      i2cm_pkg::ST_R_LO:  scl = 1'b0;
      i2cm_pkg::ST_K_SDA: sda = ack_sel ? 1'b0 : 1'b1;
      i2cm_pkg::ST_K_HI:  scl = 1'b1;
      i2cm_pkg::ST_K_LO:  scl = 1'b0;
      i2cm_pkg::ST_K_REL: sda = 1'b1;
      default:  ;
    endcase
    delay = (half_period == '0) ? '0 : half_period - 1'b1;
  endfunction

  function i2cm_pkg::res_t predict_pins(i2cm_pkg::cmd_t c);
    i2cm_pkg::res_t r;
    logic done;
    done = 1'b0;
    if (step == i2cm_pkg::ST_IDLE) begin
      if (c.cmd_valid) begin
        case (i2cm_pkg::kind_e'(c.kind))
          i2cm_pkg::KIND_START: enter_step(i2cm_pkg::ST_S_A);
          i2cm_pkg::KIND_STOP:  enter_step(i2cm_pkg::ST_P_A);
          i2cm_pkg::KIND_WRITE: begin
            shreg    = c.wr_data;
            bit_cnt  = '0;
            nack_f   = 1'b0;
            ack_wait = '0;
            enter_step(i2cm_pkg::ST_W_BIT);
          end
          default: begin
            shreg   = '0;
            bit_cnt = '0;
            ack_sel = c.send_ack;
            enter_step(i2cm_pkg::ST_R_HI);
          end
        endcase
      end
    end else if (delay != '0) begin
      delay = delay - 1'b1;
    end else begin
      case (step)
        i2cm_pkg::ST_S_A:   enter_step(i2cm_pkg::ST_S_B);
        i2cm_pkg::ST_S_B:   enter_step(i2cm_pkg::ST_S_C);
        i2cm_pkg::ST_P_A:   enter_step(i2cm_pkg::ST_P_B);
        i2cm_pkg::ST_P_B:   enter_step(i2cm_pkg::ST_P_C);
        i2cm_pkg::ST_W_BIT: enter_step(i2cm_pkg::ST_W_HI);
        i2cm_pkg::ST_W_HI:  enter_step(i2cm_pkg::ST_W_LO);
        i2cm_pkg::ST_W_LO:  begin
          if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE) enter_step(i2cm_pkg::ST_A_REL);
          else enter_step(i2cm_pkg::ST_W_BIT);
        end
        i2cm_pkg::ST_A_REL: enter_step(i2cm_pkg::ST_A_HI);
        i2cm_pkg::ST_A_HI:  begin
          if (!c.sda_in) begin
            enter_step(i2cm_pkg::ST_A_LO);
          end else if (ack_wait >= ack_timeout) begin
            nack_f = 1'b1;
            enter_step(i2cm_pkg::ST_N_LO);
          end else begin
            ack_wait = ack_wait + 1'b1;
          end
        end
        i2cm_pkg::ST_N_LO:  enter_step(i2cm_pkg::ST_N_SDA);
        i2cm_pkg::ST_N_SDA: enter_step(i2cm_pkg::ST_N_HI);
        i2cm_pkg::ST_N_HI:  enter_step(i2cm_pkg::ST_N_REL);
        i2cm_pkg::ST_R_HI:  begin
          shreg   = {shreg[i2cm_pkg::BYTE_W-2:0], c.sda_in};
          bit_cnt = bit_cnt + 1'b1;
          enter_step(i2cm_pkg::ST_R_LO);
        end
        i2cm_pkg::ST_R_LO:  begin
          if (bit_cnt >= i2cm_pkg::BITS_PER_BYTE) begin
            rdbyte = shreg;
            enter_step(i2cm_pkg::ST_K_SDA);
          end else begin
            enter_step(i2cm_pkg::ST_R_HI);
          end
        end
        i2cm_pkg::ST_K_SDA: enter_step(i2cm_pkg::ST_K_HI);
        i2cm_pkg::ST_K_HI:  enter_step(i2cm_pkg::ST_K_LO);
        i2cm_pkg::ST_K_LO:  begin
          if (ack_sel) begin
            enter_step(i2cm_pkg::ST_K_REL);
          end else begin
            step = i2cm_pkg::ST_IDLE;
            done = 1'b1;
          end
        end
        i2cm_pkg::ST_S_C, i2cm_pkg::ST_P_C, i2cm_pkg::ST_A_LO,
        i2cm_pkg::ST_N_REL, i2cm_pkg::ST_K_REL: begin
          step = i2cm_pkg::ST_IDLE;
          done = 1'b1;
        end
        default: step = i2cm_pkg::ST_IDLE;
      endcase
    end
    r.scl_out  = scl;
    r.sda_out  = sda;
    r.busy_res = (step != i2cm_pkg::ST_IDLE);
    r.done_res = done;
    r.rd_data  = rdbyte;
    r.nack     = nack_f;
    return r;
  endfunction

  function void note_tick(i2cm_pkg::cmd_t c);
    ticks_seen++;
    pins_due.push_back(predict_pins(c));
  endfunction

  function void report(string what, logic [7:0] exp_v, logic [7:0] got_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, got_v);
  endfunction

  function void check_field(string what, logic [7:0] exp_v, logic [7:0] got_v);
    if (got_v !== exp_v) report(what, exp_v, got_v);
  endfunction

  function void check_pins(i2cm_pkg::res_t got);
    i2cm_pkg::res_t exp_r;
    if (pins_due.size() == 0) begin
      report("unexpected result beat", 8'h00, 8'h01);
      return;
    end
    exp_r = pins_due.pop_front();
    check_field("scl_out", 8'(exp_r.scl_out), 8'(got.scl_out));
    check_field("sda_out", 8'(exp_r.sda_out), 8'(got.sda_out));
    check_field("busy_res", 8'(exp_r.busy_res), 8'(got.busy_res));
    check_field("done_res", 8'(exp_r.done_res), 8'(got.done_res));
    check_field("rd_data", exp_r.rd_data, got.rd_data);
    check_field("nack", 8'(exp_r.nack), 8'(got.nack));
  endfunction

  function void check_leftover();
    if (pins_due.size() != 0) report("results left over", 8'h00, 8'(pins_due.size()));
  endfunction
endclass

module tb_top;
  localparam int CLK_HALF    = 10;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_TICKS = 40;

  logic clk_i;
  logic rst_ni;
  int   idle_pct;
  int   stall_pct;
  bit   hold_req;
  int   cycles = 0;

  bus_pin_scoreboard sb = new();

  i2cm_in_if  in_if ();
  i2cm_out_if res_if ();
  i2cm_cfg_if cfg_if ();

  i2c_master_byte_engine i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("i2c_master_byte_engine verification failed");
      $finish;
    end
  end

  // Everything that crosses a handshake is recorded here, in acceptance order.
  always @(posedge clk_i) begin : monitor_blk
    i2cm_pkg::cmd_t c;
    i2cm_pkg::res_t r;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_if.index, cfg_if.data);
      if (in_if.valid && in_if.ready) begin
        c.cmd_valid = in_if.cmd_valid;
        c.kind      = in_if.kind;
        c.wr_data   = in_if.wr_data;
        c.send_ack  = in_if.send_ack;
        c.sda_in    = in_if.sda_in;
        sb.note_tick(c);
      end
      if (res_if.valid && res_if.ready) begin
        r.scl_out  = res_if.scl_out;
        r.sda_out  = res_if.sda_out;
        r.busy_res = res_if.busy_res;
        r.done_res = res_if.done_res;
        r.rd_data  = res_if.rd_data;
        r.nack     = res_if.nack;
        sb.check_pins(r);
      end
    end
  end

  // Result receiver; a hold request keeps ready low long enough to back up the input.
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Called just after a falling edge; returns just after the falling edge that
  // follows the accepting rising edge, with valid still high.
  task automatic send_tick(bit v, i2cm_pkg::kind_e k, logic [7:0] d, bit ack, bit sda);
    while ($urandom_range(99) < idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.cmd_valid <= v;
    in_if.kind      <= k;
    in_if.wr_data   <= d;
    in_if.send_ack  <= ack;
    in_if.sda_in    <= sda;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic idle_ticks(int n);
    repeat (n) begin
      send_tick(1'b0, i2cm_pkg::kind_e'($urandom_range(3)), 8'($urandom), 1'($urandom),
                1'($urandom));
    end
  endtask

  // One command beat while idle, then ticks until the sequencer is idle again.
  // Command beats offered while busy are noise that the engine must ignore.
  task automatic run_cmd(i2cm_pkg::kind_e k, logic [7:0] d, bit ack, int sda_hi_pct,
                         int noise_pct);
    send_tick(1'b1, k, d, ack, $urandom_range(99) < sda_hi_pct);
    while (sb.seq_busy()) begin
      send_tick($urandom_range(99) < noise_pct, i2cm_pkg::kind_e'($urandom_range(3)),
                8'($urandom), 1'($urandom), $urandom_range(99) < sda_hi_pct);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_one(logic [i2cm_pkg::CFG_IDX_W-1:0] idx,
                           logic [i2cm_pkg::CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic write_config(logic [15:0] hp, logic [15:0] tmo);
    write_one(i2cm_pkg::CFG_HALF_PERIOD, hp);
    write_one(i2cm_pkg::CFG_ACK_TIMEOUT, tmo);
  endtask

  function automatic int pick_sda_bias();
    case ($urandom_range(3))
      0:       return 0;
      1:       return 50;
      2:       return 85;
      default: return 100;
    endcase
  endfunction

  task automatic random_txn();
    int n;
    if ($urandom_range(9) == 0) begin
      run_cmd(i2cm_pkg::kind_e'($urandom_range(3)), 8'($urandom), 1'($urandom),
              pick_sda_bias(), 20);
    end else begin
      run_cmd(i2cm_pkg::KIND_START, 8'($urandom), 1'($urandom), 50, 10);
      n = $urandom_range(1, 2);
      repeat (n) begin
        if ($urandom_range(1) == 0) begin
          run_cmd(i2cm_pkg::KIND_WRITE, 8'($urandom), 1'($urandom), pick_sda_bias(), 10);
        end else begin
          run_cmd(i2cm_pkg::KIND_READ, 8'($urandom), 1'($urandom), 50, 10);
        end
      end
      run_cmd(i2cm_pkg::KIND_STOP, 8'($urandom), 1'($urandom), 50, 10);
    end
    if ($urandom_range(3) == 0) idle_ticks($urandom_range(1, 3));
  endtask

  task automatic run_phase(int idle, int stall, bit hold);
    int start_ticks;
    logic [15:0] hp;
    logic [15:0] tmo;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5, 6: hp = 16'($urandom_range(0, 1));
      default:             hp = 16'($urandom_range(2, 3));
    endcase
    tmo = ($urandom_range(4) == 0) ? 16'($urandom_range(20, 40)) : 16'($urandom_range(0, 8));
    write_config(hp, tmo);
    idle_pct    = idle;
    stall_pct   = stall;
    hold_req    = hold;
    start_ticks = sb.ticks_seen;
    while (sb.ticks_seen - start_ticks < PHASE_TICKS) random_txn();
    drain();
  endtask

  initial begin
    idle_pct        = 0;
    stall_pct       = 0;
    hold_req        = 1'b0;
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.cmd_valid = 1'b0;
    in_if.kind      = i2cm_pkg::KIND_START;
    in_if.wr_data   = '0;
    in_if.send_ack  = 1'b0;
    in_if.sda_in    = 1'b1;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = i2cm_pkg::CFG_HALF_PERIOD;
    cfg_if.data     = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Reset half period of 72 ticks, seen on a start condition.
    idle_ticks(3);
    run_cmd(i2cm_pkg::KIND_START, 8'h00, 1'b0, 50, 0);
    drain();

    // Reset acknowledge timeout of 250 polls, with the half period cut to one tick.
    write_one(i2cm_pkg::CFG_HALF_PERIOD, 16'd1);
    run_cmd(i2cm_pkg::KIND_WRITE, 8'hA5, 1'b0, 100, 0);
    drain();

    // Zero half period acts as one tick; zero timeout gives up on the first high poll.
    write_config(16'd0, 16'd0);
    run_cmd(i2cm_pkg::KIND_START, 8'h00, 1'b0, 50, 0);
    run_cmd(i2cm_pkg::KIND_WRITE, 8'hFF, 1'b0, 100, 0);
    run_cmd(i2cm_pkg::KIND_WRITE, 8'h00, 1'b1, 0, 0);
    run_cmd(i2cm_pkg::KIND_READ, 8'h00, 1'b1, 100, 0);
    run_cmd(i2cm_pkg::KIND_READ, 8'hFF, 1'b0, 0, 50);
    run_cmd(i2cm_pkg::KIND_STOP, 8'h00, 1'b0, 50, 100);
    idle_ticks(2);
    drain();

    run_phase(0, 0, 1'b1);
    run_phase(52, 0, 1'b0);
    run_phase(0, 52, 1'b0);
    run_phase(33, 33, 1'b0);

    repeat (10) @(posedge clk_i);
    sb.check_leftover();
    if (sb.errors == 0) begin
      $display("i2c_master_byte_engine verification clean");
    end else begin
      $display("i2c_master_byte_engine verification failed");
    end
    $finish;
  end
endmodule
